// File: sv/crde_pkg.sv
// shared types, constants and codes of the canvas raster draw engine
`timescale 1ns / 1ps
package crde_pkg;

  localparam int MaxDim = 256;
  localparam int CoordW = $clog2(MaxDim);
  localparam int DimW = CoordW + 1;
  localparam int AddrW = 2 * CoordW;
  localparam int Depth = MaxDim * MaxDim;

  localparam logic [7:0] BlankChar = 8'h20;
  localparam logic [16:0] FirstDiff = 17'd100000;

  localparam logic CfgWidthIdx = 1'b0;
  localparam logic CfgHeightIdx = 1'b1;

  typedef enum logic [1:0] {
    OP_RECT   = 2'd0,
    OP_LINE   = 2'd1,
    OP_CIRCLE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] x_first;
    logic [7:0] y_first;
    logic [7:0] x_second;
    logic [7:0] y_second;
    logic [7:0] radius;
    logic [7:0] ink;
  } in_t;

  typedef struct packed {
    logic [7:0] cell_value;
    logic       was_read;
  } out_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] x1;
    logic [7:0] y1;
    logic [7:0] x2;
    logic [7:0] y2;
    logic [7:0] radius;
    logic [7:0] ink;
  } cmd_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] fill;
    cmd_t       cmd;
  } queue_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

endpackage

// File: sv/crde_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module crde_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/crde_front.sv
// command front end: accepts, orders end points and queues commands
`timescale 1ns / 1ps
module crde_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  crde_pkg::in_t           in_data,
  input  crde_pkg::back_stat_t    stat,
  output crde_pkg::queue_t        q
);
  import crde_pkg::*;

  cmd_t       head_r, head_nxt;
  cmd_t       tail_r, tail_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cls;
  logic       push;
  logic       swap;

  always_comb begin
    cls.op = op_e'(in_data.operation);
    cls.radius = in_data.radius;
    cls.ink = in_data.ink;
    cls.x1 = in_data.x_first;
    cls.y1 = in_data.y_first;
    cls.x2 = in_data.x_second;
    cls.y2 = in_data.y_second;
    swap = 1'b0;
    case (op_e'(in_data.operation))
      OP_RECT: begin
        if (in_data.x_second < in_data.x_first) begin
          cls.x1 = in_data.x_second;
          cls.x2 = in_data.x_first;
        end
        if (in_data.y_second < in_data.y_first) begin
          cls.y1 = in_data.y_second;
          cls.y2 = in_data.y_first;
        end
      end
      OP_LINE: begin
        swap = (in_data.x_first >= in_data.x_second && in_data.y_first >= in_data.y_second) ||
               (in_data.x_first > in_data.x_second && in_data.y_first < in_data.y_second);
        if (swap) begin
          cls.x1 = in_data.x_second;
          cls.y1 = in_data.y_second;
          cls.x2 = in_data.x_first;
          cls.y2 = in_data.y_first;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready = (cnt_r != 2'd2) && !stat.clearing;
  assign push = in_valid && in_ready;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, stat.pop};
    if (stat.pop) begin
      head_nxt = (cnt_r == 2'd2) ? tail_r : cls;
    end else if (push && cnt_r == 2'd0) begin
      head_nxt = cls;
    end
    if (push && ((cnt_r == 2'd1 && !stat.pop) || (cnt_r == 2'd2 && stat.pop))) begin
      tail_nxt = cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign q.valid = (cnt_r != 2'd0);
  assign q.fill = cnt_r;
  assign q.cmd = head_r;

endmodule

// File: sv/crde_back.sv
// drawing back end: clear pass, rectangle, line, circle and read sequencer
`timescale 1ns / 1ps
module crde_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  crde_pkg::queue_t             q,
  output crde_pkg::back_stat_t         stat,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [crde_pkg::DimW-1:0]    cfg_wdata,
  output logic                         out_valid,
  input  logic                         out_ready,
  output crde_pkg::out_t               out_data,
  output logic                         ram_we,
  output logic [crde_pkg::AddrW-1:0]   ram_waddr,
  output logic [7:0]                   ram_wdata,
  output logic                         ram_re,
  output logic [crde_pkg::AddrW-1:0]   ram_raddr,
  input  logic [7:0]                   ram_rdata
);
  import crde_pkg::*;

  typedef enum logic [18:0] {
    S_CLEAR  = 19'd1 << 0,
    S_IDLE   = 19'd1 << 1,
    S_RECT_H = 19'd1 << 2,
    S_RECT_V = 19'd1 << 3,
    S_LINE_V = 19'd1 << 4,
    S_DIV    = 19'd1 << 5,
    S_COL    = 19'd1 << 6,
    S_RUN    = 19'd1 << 7,
    S_LEND   = 19'd1 << 8,
    S_CIRC0  = 19'd1 << 9,
    S_CIRC1  = 19'd1 << 10,
    S_CCHK   = 19'd1 << 11,
    S_CSQ    = 19'd1 << 12,
    S_CSQRT  = 19'd1 << 13,
    S_CSCORE = 19'd1 << 14,
    S_CPLOT  = 19'd1 << 15,
    S_READ   = 19'd1 << 16,
    S_READW  = 19'd1 << 17,
    S_DONE   = 19'd1 << 18
  } state_t;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [DimW-1:0]    cfg_w_r, cfg_w_nxt, cfg_h_r, cfg_h_nxt;
  logic [AddrW-1:0]   clr_r, clr_nxt;
  logic [9:0]         i_r, i_nxt;
  logic [1:0]         ph_r, ph_nxt;
  logic [24:0]        dvd_r, dvd_nxt;
  logic [7:0]         rem_r, rem_nxt;
  logic [4:0]         ctr_r, ctr_nxt;
  logic [24:0]        mag_r, mag_nxt;
  logic [24:0]        off_r, off_nxt;
  logic [7:0]         j_r, j_nxt;
  logic [9:0]         prev_r, prev_nxt;
  logic [9:0]         rd_r, rd_nxt;
  logic               fall_r, fall_nxt;
  logic signed [10:0] a_r, a_nxt, b_r, b_nxt, na_r, na_nxt, nb_r, nb_nxt;
  logic [16:0]        best_r, best_nxt;
  logic [1:0]         k_r, k_nxt;
  logic [9:0]         steps_r, steps_nxt;
  logic [35:0]        sv_r, sv_nxt, sres_r, sres_nxt, sbit_r, sbit_nxt;
  logic               rdok_r, rdok_nxt;
  out_t               res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic [DimW-1:0]    w_eff, h_eff;
  logic signed [11:0] px, py, row_s, w_s, h_s;
  logic               pen, on_canvas, pop;
  logic [7:0]         dx, dy_q;
  logic [8:0]         rem_sh;
  logic               geq;
  logic [25:0]        mag_sum;
  logic signed [26:0] ybase, offs, yq, yr;
  logic signed [10:0] ca, cb;
  logic signed [21:0] sqa, sqb;
  logic [21:0]        sqs;
  logic [35:0]        st;
  logic [17:0]        dval, want, sc;
  logic               better;
  logic signed [11:0] cx_s, cy_s, a_s, b_s, r_s;

  assign w_eff = (cfg_w_r > DimW'(MaxDim)) ? DimW'(MaxDim) : cfg_w_r;
  assign h_eff = (cfg_h_r > DimW'(MaxDim)) ? DimW'(MaxDim) : cfg_h_r;
  assign w_s = $signed({3'b000, w_eff});
  assign h_s = $signed({3'b000, h_eff});
  assign on_canvas = (px >= 12'sd0) && (px < w_s) && (py >= 12'sd0) && (py < h_s);
  assign row_s = h_s - 12'sd1 - py;

  assign cx_s = $signed({4'b0000, cmd_r.x1});
  assign cy_s = $signed({4'b0000, cmd_r.y1});
  assign r_s = $signed({4'b0000, cmd_r.radius});
  assign a_s = {a_r[10], a_r};
  assign b_s = {b_r[10], b_r};

  assign dx = cmd_r.x2 - cmd_r.x1;
  assign dy_q = (q.cmd.y1 >= q.cmd.y2) ? q.cmd.y1 - q.cmd.y2 : q.cmd.y2 - q.cmd.y1;
  assign rem_sh = {rem_r, dvd_r[24]};
  assign geq = rem_sh >= {1'b0, dx};

  assign ybase = $signed({3'b000, cmd_r.y1, 16'h0000});
  assign offs = $signed({2'b00, off_r});

  assign ca = (k_r != 2'd1) ? a_r + 11'sd1 : a_r;
  assign cb = (k_r != 2'd0) ? b_r - 11'sd1 : b_r;
  assign sqa = ca * ca;
  assign sqb = cb * cb;
  assign sqs = 22'(sqa) + 22'(sqb);
  assign st = sres_r + sbit_r;
  assign dval = sres_r[17:0];
  assign want = {2'b00, cmd_r.radius, 8'h00};
  assign sc = (dval > want) ? dval - want : want - dval;
  assign better = sc < {1'b0, best_r};

  // point to plot in this cycle
  always_comb begin
    px = 12'sd0;
    py = 12'sd0;
    pen = 1'b0;
    unique case (state_r)
      S_RECT_H: begin
        pen = 1'b1;
        px = $signed({2'b00, i_r});
        py = $signed({4'b0000, (ph_r[0] ? cmd_r.y2 : cmd_r.y1)});
      end
      S_RECT_V: begin
        pen = 1'b1;
        px = $signed({4'b0000, (ph_r[0] ? cmd_r.x2 : cmd_r.x1)});
        py = $signed({2'b00, i_r});
      end
      S_LINE_V: begin
        pen = 1'b1;
        px = cx_s;
        py = $signed({2'b00, i_r});
      end
      S_RUN: begin
        pen = 1'b1;
        px = $signed({4'b0000, j_r});
        py = $signed({2'b00, i_r});
      end
      S_LEND: begin
        pen = 1'b1;
        px = $signed({4'b0000, cmd_r.x2});
        py = $signed({4'b0000, cmd_r.y2});
      end
      S_CIRC0: begin
        pen = 1'b1;
        px = cx_s;
        py = cy_s + r_s;
      end
      S_CIRC1: begin
        pen = 1'b1;
        px = cx_s;
        py = cy_s - r_s;
      end
      S_CPLOT: begin
        pen = 1'b1;
        px = ph_r[0] ? cx_s - a_s : cx_s + a_s;
        py = ph_r[1] ? cy_s - b_s : cy_s + b_s;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    cfg_w_nxt = cfg_w_r;
    cfg_h_nxt = cfg_h_r;
    clr_nxt = clr_r;
    i_nxt = i_r;
    ph_nxt = ph_r;
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    ctr_nxt = ctr_r;
    mag_nxt = mag_r;
    off_nxt = off_r;
    j_nxt = j_r;
    prev_nxt = prev_r;
    rd_nxt = rd_r;
    fall_nxt = fall_r;
    a_nxt = a_r;
    b_nxt = b_r;
    na_nxt = na_r;
    nb_nxt = nb_r;
    best_nxt = best_r;
    k_nxt = k_r;
    steps_nxt = steps_r;
    sv_nxt = sv_r;
    sres_nxt = sres_r;
    sbit_nxt = sbit_r;
    rdok_nxt = rdok_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    pop = 1'b0;
    ram_re = 1'b0;
    ram_raddr = {cmd_r.y1, cmd_r.x1};
    mag_sum = 26'd0;
    yq = 27'sd0;
    yr = 27'sd0;

    if (cfg_we) begin
      if (cfg_index == CfgWidthIdx) begin
        cfg_w_nxt = cfg_wdata;
      end else begin
        cfg_h_nxt = cfg_wdata;
      end
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + AddrW'(1);
        if (clr_r == {AddrW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q.valid) begin
          pop = 1'b1;
          cmd_nxt = q.cmd;
          res_nxt = '0;
          ph_nxt = 2'd0;
          unique case (q.cmd.op)
            OP_RECT: begin
              i_nxt = {2'b00, q.cmd.x1};
              state_nxt = S_RECT_H;
            end
            OP_LINE: begin
              if (q.cmd.x1 == q.cmd.x2) begin
                i_nxt = {2'b00, q.cmd.y1};
                state_nxt = S_LINE_V;
              end else begin
                fall_nxt = q.cmd.y1 >= q.cmd.y2;
                dvd_nxt = {dy_q, 17'h00000};
                rem_nxt = 8'd0;
                ctr_nxt = 5'd0;
                state_nxt = S_DIV;
              end
            end
            OP_CIRCLE: begin
              state_nxt = S_CIRC0;
            end
            OP_READ: begin
              state_nxt = S_READ;
            end
            default: begin
            end
          endcase
        end
      end
      S_RECT_H: begin
        ph_nxt = {1'b0, ~ph_r[0]};
        if (ph_r[0]) begin
          if (i_r == {2'b00, cmd_r.x2}) begin
            i_nxt = {2'b00, cmd_r.y1};
            state_nxt = S_RECT_V;
          end else begin
            i_nxt = i_r + 10'd1;
          end
        end
      end
      S_RECT_V: begin
        ph_nxt = {1'b0, ~ph_r[0]};
        if (ph_r[0]) begin
          if (i_r == {2'b00, cmd_r.y2}) begin
            state_nxt = S_DONE;
          end else begin
            i_nxt = i_r + 10'd1;
          end
        end
      end
      S_LINE_V: begin
        if (i_r == {2'b00, cmd_r.y2}) begin
          state_nxt = S_DONE;
        end else begin
          i_nxt = i_r + 10'd1;
        end
      end
      S_DIV: begin
        rem_nxt = geq ? 8'(rem_sh - {1'b0, dx}) : rem_sh[7:0];
        dvd_nxt = {dvd_r[23:0], geq};
        ctr_nxt = ctr_r + 5'd1;
        if (ctr_r == 5'd24) begin
          mag_sum = {1'b0, dvd_nxt} + 26'd1;
          mag_nxt = mag_sum[25:1];
          j_nxt = cmd_r.x1;
          off_nxt = 25'd0;
          prev_nxt = {2'b00, cmd_r.y1};
          state_nxt = S_COL;
        end
      end
      S_COL: begin
        yq = fall_r ? ybase - offs : ybase + offs;
        if (yq < 27'sd0) begin
          yq = 27'sd0;
        end
        yr = yq + 27'sd32768;
        rd_nxt = yr[25:16];
        i_nxt = prev_r;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (i_r == rd_r) begin
          prev_nxt = rd_r;
          if (j_r == cmd_r.x2) begin
            state_nxt = S_LEND;
          end else begin
            j_nxt = j_r + 8'd1;
            off_nxt = off_r + mag_r;
            state_nxt = S_COL;
          end
        end else begin
          i_nxt = fall_r ? i_r - 10'd1 : i_r + 10'd1;
        end
      end
      S_LEND: begin
        state_nxt = S_DONE;
      end
      S_CIRC0: begin
        state_nxt = S_CIRC1;
      end
      S_CIRC1: begin
        a_nxt = 11'sd0;
        b_nxt = $signed({3'b000, cmd_r.radius});
        steps_nxt = 10'd0;
        state_nxt = S_CCHK;
      end
      S_CCHK: begin
        if ((a_r != $signed({3'b000, cmd_r.radius}) || b_r != 11'sd0) &&
            (steps_r < {1'b0, cmd_r.radius, 1'b0})) begin
          k_nxt = 2'd0;
          best_nxt = FirstDiff;
          na_nxt = a_r;
          nb_nxt = b_r;
          state_nxt = S_CSQ;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_CSQ: begin
        sv_nxt = {sqs[19:0], 16'h0000};
        sres_nxt = 36'd0;
        sbit_nxt = 36'd1 << 34;
        ctr_nxt = 5'd0;
        state_nxt = S_CSQRT;
      end
      S_CSQRT: begin
        if (sv_r >= st) begin
          sv_nxt = sv_r - st;
          sres_nxt = (sres_r >> 1) + sbit_r;
        end else begin
          sres_nxt = sres_r >> 1;
        end
        sbit_nxt = sbit_r >> 2;
        ctr_nxt = ctr_r + 5'd1;
        if (ctr_r == 5'd17) begin
          state_nxt = S_CSCORE;
        end
      end
      S_CSCORE: begin
        if (better) begin
          best_nxt = sc[16:0];
          na_nxt = ca;
          nb_nxt = cb;
        end
        if (k_r == 2'd2) begin
          a_nxt = better ? ca : na_r;
          b_nxt = better ? cb : nb_r;
          ph_nxt = 2'd0;
          state_nxt = S_CPLOT;
        end else begin
          k_nxt = k_r + 2'd1;
          state_nxt = S_CSQ;
        end
      end
      S_CPLOT: begin
        ph_nxt = ph_r + 2'd1;
        if (ph_r == 2'd3) begin
          steps_nxt = steps_r + 10'd1;
          state_nxt = S_CCHK;
        end
      end
      S_READ: begin
        rdok_nxt = ({1'b0, cmd_r.x1} < w_eff) && ({1'b0, cmd_r.y1} < h_eff);
        ram_re = 1'b1;
        ram_raddr = {8'(h_eff - DimW'(1) - {1'b0, cmd_r.y1}), cmd_r.x1};
        state_nxt = S_READW;
      end
      S_READW: begin
        res_nxt.cell_value = rdok_r ? ram_rdata : 8'd0;
        res_nxt.was_read = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      cfg_w_r <= DimW'(64);
      cfg_h_r <= DimW'(64);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      cfg_w_r <= cfg_w_nxt;
      cfg_h_r <= cfg_h_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r <= cmd_nxt;
    i_r <= i_nxt;
    ph_r <= ph_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    ctr_r <= ctr_nxt;
    mag_r <= mag_nxt;
    off_r <= off_nxt;
    j_r <= j_nxt;
    prev_r <= prev_nxt;
    rd_r <= rd_nxt;
    fall_r <= fall_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    na_r <= na_nxt;
    nb_r <= nb_nxt;
    best_r <= best_nxt;
    k_r <= k_nxt;
    steps_r <= steps_nxt;
    sv_r <= sv_nxt;
    sres_r <= sres_nxt;
    sbit_r <= sbit_nxt;
    rdok_r <= rdok_nxt;
    res_r <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign ram_we = (state_r == S_CLEAR) || (pen && on_canvas);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_r : {row_s[CoordW-1:0], px[CoordW-1:0]};
  assign ram_wdata = (state_r == S_CLEAR) ? BlankChar : cmd_r.ink;

  assign stat.clearing = (state_r == S_CLEAR);
  assign stat.pop = pop;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

// File: sv/canvas_raster_draw_engine.sv
// top level of the canvas raster draw engine
// steps: a read uses the registered ram read port; a rectangle plots its edges;
// a line runs a slope division, then per column a step and a run of cells;
// a circle plots top and bottom, then per walk step a check, 3 roots and 4 plot points.
// throughput: one command at a time in the back end, set by the single canvas write port
// reset: synchronous active low; a clearing pass fills all 65536 canvas cells with
// spaces, in_ready stays low until it ends, configuration writes are taken throughout
`timescale 1ns / 1ps
module canvas_raster_draw_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  crde_pkg::in_t             in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output crde_pkg::out_t            out_data,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [crde_pkg::DimW-1:0] cfg_wdata
);
  import crde_pkg::*;

  queue_t           q;
  back_stat_t       stat;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  crde_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .stat     (stat),
    .q        (q)
  );

  crde_ram #(
    .Width (8),
    .Depth (Depth)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  crde_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q         (q),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

`ifndef ASSERT_OFF
  a_clear_blocks_input: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input accepted during canvas clear");
  a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n) q.fill != 2'd3)
    else $error("command queue overfilled");
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !stat.pop)
    else $error("command taken during canvas clear");
  a_draw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.was_read |-> out_data.cell_value == 8'd0)
    else $error("draw transaction carries data");
`endif

endmodule

// File: verif/crde_scoreboard.sv
// checker for the canvas raster draw engine: mirrors the canvas and compares each result
`timescale 1ns / 1ps
module crde_scoreboard
  import crde_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  in_t             in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  out_t            out_data,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [DimW-1:0] cfg_wdata,
  output int              fail_count,
  output int              pending
);

  logic [7:0] canvas_cells [0:Depth-1];
  logic [DimW-1:0] width_reg;
  logic [DimW-1:0] height_reg;
  out_t expected_results [$];

  function automatic int used_dim(logic [DimW-1:0] v);
    return (v > MaxDim) ? MaxDim : int'(v);
  endfunction

  function automatic void put_cell(int x, int y, logic [7:0] ink);
    int w;
    int h;
    w = used_dim(width_reg);
    h = used_dim(height_reg);
    if (x >= 0 && x < w && y >= 0 && y < h) begin
      canvas_cells[(h - 1 - y) * MaxDim + x] = ink;
    end
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic void draw_outline(int xa, int ya, int xb, int yb, logic [7:0] ink);
    int lx;
    int hx;
    int ly;
    int hy;
    lx = (xa < xb) ? xa : xb;
    hx = (xa < xb) ? xb : xa;
    ly = (ya < yb) ? ya : yb;
    hy = (ya < yb) ? yb : ya;
    for (int i = lx; i <= hx; i++) begin
      put_cell(i, ly, ink);
      put_cell(i, hy, ink);
    end
    for (int i = ly; i <= hy; i++) begin
      put_cell(lx, i, ink);
      put_cell(hx, i, ink);
    end
  endfunction

  function automatic void draw_segment(int x1, int y1, int x2, int y2, logic [7:0] ink);
    int t;
    int prev;
    int rd;
    bit falling;
    longint dx;
    longint dy;
    longint mag;
    longint off;
    longint yq;
    if ((x1 >= x2 && y1 >= y2) || (x1 > x2 && y1 < y2)) begin
      t = x1; x1 = x2; x2 = t;
      t = y1; y1 = y2; y2 = t;
    end
    if (x1 == x2) begin
      for (int i = y1; i <= y2; i++) put_cell(x1, i, ink);
      return;
    end
    falling = (y1 >= y2);
    dx = x2 - x1;
    dy = falling ? (y1 - y2) : (y2 - y1);
    mag = (((dy << 17) / dx) + 1) >>> 1;
    prev = y1;
    for (int j = x1; j <= x2; j++) begin
      off = mag * (j - x1);
      yq = longint'(y1) * 65536 + (falling ? -off : off);
      if (yq < 0) yq = 0;
      rd = int'((yq + 32768) >>> 16);
      put_cell(j, prev, ink);
      if (!falling) begin
        for (int i = prev; i <= rd; i++) put_cell(j, i, ink);
      end else begin
        for (int i = prev; i >= rd; i--) put_cell(j, i, ink);
      end
      prev = rd;
    end
    put_cell(x2, y2, ink);
  endfunction

  function automatic longint unsigned ring_error(int a, int b, int r);
    longint unsigned d;
    longint unsigned want;
    d = int_root(longint'(a * a + b * b) << 16);
    want = longint'(r) << 8;
    return (d > want) ? d - want : want - d;
  endfunction

  function automatic void draw_ring(int cx, int cy, int r, logic [7:0] ink);
    int a;
    int b;
    int steps;
    int na;
    int nb;
    longint unsigned best;
    longint unsigned s;
    a = 0;
    b = r;
    steps = 0;
    put_cell(cx, cy + r, ink);
    put_cell(cx, cy - r, ink);
    while ((a != r || b != 0) && steps < 2 * r) begin
      best = FirstDiff;
      na = a;
      nb = b;
      s = ring_error(a + 1, b, r);
      if (s < best) begin best = s; na = a + 1; nb = b; end
      s = ring_error(a, b - 1, r);
      if (s < best) begin best = s; na = a; nb = b - 1; end
      s = ring_error(a + 1, b - 1, r);
      if (s < best) begin best = s; na = a + 1; nb = b - 1; end
      a = na;
      b = nb;
      put_cell(cx + a, cy + b, ink);
      put_cell(cx - a, cy + b, ink);
      put_cell(cx + a, cy - b, ink);
      put_cell(cx - a, cy - b, ink);
      steps++;
    end
  endfunction

  function automatic out_t run_command(in_t c);
    out_t res;
    int w;
    int h;
    res = '0;
    case (op_e'(c.operation))
      OP_RECT: draw_outline(c.x_first, c.y_first, c.x_second, c.y_second, c.ink);
      OP_LINE: draw_segment(c.x_first, c.y_first, c.x_second, c.y_second, c.ink);
      OP_CIRCLE: draw_ring(c.x_first, c.y_first, c.radius, c.ink);
      default: begin
        w = used_dim(width_reg);
        h = used_dim(height_reg);
        if (c.x_first < w && c.y_first < h) begin
          res.cell_value = canvas_cells[(h - 1 - c.y_first) * MaxDim + c.x_first];
        end
        res.was_read = 1'b1;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    out_t exp_res;
    int errs;
    errs = 0;
    if (!rst_n) begin
      for (int i = 0; i < Depth; i++) canvas_cells[i] = BlankChar;
      width_reg = 9'd64;
      height_reg = 9'd64;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected: cell_value %0h was_read %0b",
                 out_data.cell_value, out_data.was_read);
          errs++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_data.cell_value !== exp_res.cell_value) begin
            $error("cell_value expected %0h actual %0h", exp_res.cell_value,
                   out_data.cell_value);
            errs++;
          end
          if (out_data.was_read !== exp_res.was_read) begin
            $error("was_read expected %0b actual %0b", exp_res.was_read, out_data.was_read);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(run_command(in_data));
      if (cfg_we) begin
        if (cfg_index == CfgWidthIdx) width_reg = cfg_wdata;
        else height_reg = cfg_wdata;
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
    pending = expected_results.size();
  end

endmodule

// File: verif/tb_canvas_raster_draw_engine.sv
// testbench top of the canvas raster draw engine: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module tb_canvas_raster_draw_engine;
  import crde_pkg::*;

  localparam int StallLimit = 300000;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  in_t             in_data;
  logic            out_valid;
  logic            out_ready;
  out_t            out_data;
  logic            cfg_we;
  logic            cfg_index;
  logic [DimW-1:0] cfg_wdata;
  int              fail_count;
  int              pending;
  int              quiet_cycles;
  bit              no_gaps;
  int              cur_w;
  int              cur_h;

  canvas_raster_draw_engine i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  crde_scoreboard i_scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= no_gaps || ($urandom_range(0, 99) >= 24);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(op_e op, int xa, int ya, int xb, int yb, int r, int ink);
    in_t c;
    c.operation = op;
    c.x_first = xa[7:0];
    c.y_first = ya[7:0];
    c.x_second = xb[7:0];
    c.y_second = yb[7:0];
    c.radius = r[7:0];
    c.ink = ink[7:0];
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!no_gaps && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic set_canvas(int w, int h);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CfgWidthIdx;
    cfg_wdata <= w[DimW-1:0];
    @(posedge clk);
    cfg_index <= CfgHeightIdx;
    cfg_wdata <= h[DimW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_w = (w > MaxDim) ? MaxDim : w;
    cur_h = (h > MaxDim) ? MaxDim : h;
  endtask

  function automatic int pick_coord(int lim);
    if (lim > 0 && $urandom_range(0, 99) < 85) return $urandom_range(0, lim - 1);
    return $urandom_range(0, 255);
  endfunction

  function automatic int pick_radius();
    if ($urandom_range(0, 99) < 4) return $urandom_range(0, 255);
    return $urandom_range(0, 14);
  endfunction

  task automatic random_cmds(int n);
    op_e op;
    int big;
    for (int k = 0; k < n; k++) begin
      op = op_e'($urandom_range(0, 3));
      big = (cur_w > cur_h) ? cur_w : cur_h;
      send_cmd(op, pick_coord(cur_w), pick_coord(cur_h), pick_coord(cur_w),
               pick_coord(cur_h), pick_radius(), $urandom_range(0, 255));
      if (big > 0 && $urandom_range(0, 99) < 30) begin
        send_cmd(OP_READ, pick_coord(cur_w), pick_coord(cur_h), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CfgWidthIdx;
    cfg_wdata = '0;
    no_gaps = 1'b0;
    cur_w = 64;
    cur_h = 64;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed commands on the reset canvas
    send_cmd(OP_RECT, 0, 0, 255, 255, 0, 8'hff);
    send_cmd(OP_READ, 0, 0, 0, 0, 0, 0);
    send_cmd(OP_READ, 63, 63, 0, 0, 0, 0);
    send_cmd(OP_RECT, 40, 30, 10, 5, 0, 8'h2a);
    send_cmd(OP_LINE, 20, 2, 20, 50, 0, 8'h41);
    send_cmd(OP_LINE, 20, 50, 20, 2, 0, 8'h42);
    send_cmd(OP_LINE, 3, 17, 60, 17, 0, 8'h43);
    send_cmd(OP_LINE, 1, 1, 62, 40, 0, 8'h44);
    send_cmd(OP_LINE, 50, 5, 2, 60, 0, 8'h45);
    send_cmd(OP_LINE, 30, 60, 33, 0, 0, 8'h46);
    send_cmd(OP_LINE, 0, 255, 255, 0, 0, 8'h00);
    send_cmd(OP_CIRCLE, 32, 32, 0, 0, 0, 8'h47);
    send_cmd(OP_CIRCLE, 2, 3, 0, 0, 10, 8'h48);
    send_cmd(OP_CIRCLE, 32, 32, 0, 0, 20, 8'h49);
    send_cmd(OP_READ, 32, 52, 0, 0, 0, 0);
    send_cmd(OP_READ, 32, 32, 0, 0, 0, 0);
    send_cmd(OP_READ, 64, 10, 0, 0, 0, 0);
    send_cmd(OP_READ, 255, 255, 255, 255, 255, 255);
    send_cmd(OP_READ, 20, 17, 0, 0, 0, 0);

    set_canvas(511, 300);
    send_cmd(OP_CIRCLE, 128, 128, 0, 0, 255, 8'h50);
    send_cmd(OP_READ, 128, 255, 0, 0, 0, 0);
    send_cmd(OP_RECT, 255, 255, 0, 0, 0, 8'h51);
    send_cmd(OP_READ, 255, 0, 0, 0, 0, 0);
    random_cmds(80);

    set_canvas(1, 1);
    send_cmd(OP_RECT, 0, 0, 0, 0, 0, 8'h52);
    send_cmd(OP_READ, 0, 0, 0, 0, 0, 0);
    random_cmds(50);

    set_canvas(0, 5);
    random_cmds(40);

    set_canvas(17, 200);
    no_gaps = 1'b1;
    random_cmds(90);
    no_gaps = 1'b0;

    set_canvas(256, 256);
    random_cmds(90);

    set_canvas($urandom_range(1, 511), $urandom_range(1, 511));
    random_cmds(60);

    set_canvas(64, 0);
    random_cmds(30);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/crde_pkg.sv
sv/crde_ram.sv
sv/crde_front.sv
sv/crde_back.sv
sv/canvas_raster_draw_engine.sv
verif/crde_scoreboard.sv
verif/tb_canvas_raster_draw_engine.sv
